// ===== hdl/wrts_pkg.sv =====
// Shared constants, codes and types of the weighted random table selector.
package wrts_pkg;

   // Table geometry
   localparam int TABLE_DEPTH = 64;
   localparam int KEY_SPACE   = 64;
   localparam int WEIGHT_BITS = 16;

   localparam int ADDR_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);

   // Field widths
   localparam int FUNC_W    = 2;
   localparam int KEY_W     = 6;
   localparam int WIN_W     = 16;
   localparam int RND_W     = 32;
   localparam int STAT_W    = 2;
   localparam int COUNT_W   = 7;
   localparam int TOTAL_W   = 22;
   localparam int RND_CNT_W = $clog2(RND_W);

   // Configuration registers
   localparam int MASK_W     = 64;
   localparam int LIMIT_W    = 7;
   localparam int AVOID_W    = 7;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 64;

   localparam logic [CSR_IDX_W-1:0] CSR_VALID_MASK  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INDEX_LIMIT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_AVOID_INDEX = 2'd2;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;
   localparam logic [AVOID_W-1:0] AVOID_RESET = 7'h7F;

   // Function codes
   localparam logic [FUNC_W-1:0] FUNC_CLEAR      = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_ADD        = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_PICK       = 2'd2;
   localparam logic [FUNC_W-1:0] FUNC_PICK_AVOID = 2'd3;

   // Status codes
   localparam logic [STAT_W-1:0] STAT_DONE   = 2'd0;
   localparam logic [STAT_W-1:0] STAT_REJECT = 2'd1;
   localparam logic [STAT_W-1:0] STAT_EMPTY  = 2'd2;

   // One table entry as held in memory
   typedef struct packed {
      logic [KEY_W-1:0]       key;
      logic [WEIGHT_BITS-1:0] weight;
   } entry_type;

endpackage

// ===== hdl/wrts_req_if.sv =====
// Request channel: operation, key, weight and random word.
interface wrts_req_if;
   logic                        valid;
   logic                        ready;
   logic [wrts_pkg::FUNC_W-1:0] func;
   logic [wrts_pkg::KEY_W-1:0]  entry_key;
   logic [wrts_pkg::WIN_W-1:0]  entry_weight_in;
   logic [wrts_pkg::RND_W-1:0]  random_word;

   modport source (output valid, func, entry_key, entry_weight_in, random_word,
                   input ready);
   modport sink   (input valid, func, entry_key, entry_weight_in, random_word,
                   output ready);
endinterface

// ===== hdl/wrts_rsp_if.sv =====
// Response channel: status, picked key, entry count and weight total.
interface wrts_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [wrts_pkg::STAT_W-1:0]  status;
   logic [wrts_pkg::KEY_W-1:0]   picked_key;
   logic [wrts_pkg::COUNT_W-1:0] count_out;
   logic [wrts_pkg::TOTAL_W-1:0] total_out;

   modport source (output valid, status, picked_key, count_out, total_out,
                   input ready);
   modport sink   (input valid, status, picked_key, count_out, total_out,
                   output ready);
endinterface

// ===== hdl/weighted_random_table_selector.sv =====
// Weighted random table selector: a table of up to 64 (key, weight) entries in
// one single-port synchronous memory, with a running weight total. Clear and
// add transactions go from acceptance through S_DONE to a loaded response. A
// plain pick first reduces the random word modulo the total in the
// one-bit-per-cycle remainder unit, then walks over the cumulative weights,
// reading one entry per cycle from the memory port and stopping at the first
// hit. An avoiding pick, when an avoided key is set, first makes a pass over
// the memory that sums the weights of the entries not carrying the avoided
// key. One transaction is in work at a time; a new request is accepted while
// the previous response still waits in the output register.
module weighted_random_table_selector (
   input  logic                              clock,
   input  logic                              reset,
   wrts_req_if.sink                          req_bus,
   wrts_rsp_if.source                        rsp_bus,
   input  logic                              csr_we,
   input  logic [wrts_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [wrts_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_SUM  = 3'd1;
   localparam logic [2:0] S_DIV  = 3'd2;
   localparam logic [2:0] S_WALK = 3'd3;
   localparam logic [2:0] S_DONE = 3'd4;

   localparam int ADDR_W  = wrts_pkg::ADDR_W;
   localparam int CNT_W   = wrts_pkg::CNT_W;
   localparam int TOTAL_W = wrts_pkg::TOTAL_W;
   localparam int KEY_W   = wrts_pkg::KEY_W;
   localparam int RND_W   = wrts_pkg::RND_W;
   localparam int WB      = wrts_pkg::WEIGHT_BITS;

   // Configuration registers
   logic [wrts_pkg::MASK_W-1:0]  mask_ff;
   logic [wrts_pkg::LIMIT_W-1:0] limit_ff;
   logic [wrts_pkg::AVOID_W-1:0] avoid_ff;

   // Control and datapath registers
   logic [2:0]                    state_ff, state_in;
   logic [CNT_W-1:0]              count_ff, count_in;
   logic [TOTAL_W-1:0]            total_ff, total_in;
   logic [CNT_W-1:0]              idx_ff, idx_in;
   logic [ADDR_W-1:0]             rd_idx_ff, rd_idx_in;
   logic                          rv_ff, rv_in;
   logic                          skip_ff, skip_in;
   logic                          found_ff, found_in;
   logic [KEY_W-1:0]              pick_ff, pick_in;
   logic [wrts_pkg::STAT_W-1:0]   status_ff, status_in;
   logic [RND_W-1:0]              rnd_ff, rnd_in;
   logic [wrts_pkg::RND_CNT_W-1:0] bit_cnt_ff, bit_cnt_in;
   logic [TOTAL_W-1:0]            div_ff, div_in;
   logic [TOTAL_W-1:0]            rem_ff, rem_in;
   logic [TOTAL_W-1:0]            acc_ff, acc_in;

   // Response register
   logic                          rsp_vld_ff, rsp_vld_in;
   logic [wrts_pkg::STAT_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [KEY_W-1:0]              rsp_key_ff, rsp_key_in;
   logic [wrts_pkg::COUNT_W-1:0]  rsp_count_ff, rsp_count_in;
   logic [TOTAL_W-1:0]            rsp_total_ff, rsp_total_in;

   // Table memory
   wrts_pkg::entry_type           mem_ff [wrts_pkg::TABLE_DEPTH];
   wrts_pkg::entry_type           rdata_ff;
   wrts_pkg::entry_type           wr_entry;
   logic                          mem_we;

   logic                          accept;
   logic                          out_free;
   logic                          avoid_on;
   logic                          rd_avoided;
   logic                          issue;
   logic [WB-1:0]                 new_weight;
   logic                          add_ok;
   logic [TOTAL_W-1:0]            rd_weight;
   logic [TOTAL_W:0]              trial;
   logic [TOTAL_W:0]              trial_sub;

   assign req_bus.ready = (state_ff == S_IDLE);
   assign accept        = req_bus.valid && req_bus.ready;
   assign out_free      = !rsp_vld_ff || rsp_bus.ready;

   assign avoid_on   = !avoid_ff[wrts_pkg::AVOID_W-1];
   assign rd_avoided = avoid_on && (rdata_ff.key == avoid_ff[KEY_W-1:0]);
   assign rd_weight  = TOTAL_W'(rdata_ff.weight);
   assign new_weight = req_bus.entry_weight_in[WB-1:0];

   assign add_ok = ({1'b0, req_bus.entry_key} < limit_ff)
                   && (int'(req_bus.entry_key) < wrts_pkg::KEY_SPACE)
                   && mask_ff[req_bus.entry_key]
                   && (count_ff < CNT_W'(wrts_pkg::TABLE_DEPTH))
                   && (new_weight != '0);

   assign wr_entry.key    = req_bus.entry_key;
   assign wr_entry.weight = new_weight;

   // One memory read per cycle while a pass over the table is running
   assign issue = (idx_ff < count_ff)
                  && ((state_ff == S_SUM) || ((state_ff == S_WALK) && !found_ff));

   // Restoring remainder step: one random bit per cycle
   assign trial     = {rem_ff, rnd_ff[RND_W-1]};
   assign trial_sub = trial - {1'b0, div_ff};

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      total_in   = total_ff;
      idx_in     = idx_ff;
      rd_idx_in  = idx_ff[ADDR_W-1:0];
      rv_in      = issue;
      skip_in    = skip_ff;
      found_in   = found_ff;
      pick_in    = pick_ff;
      status_in  = status_ff;
      rnd_in     = rnd_ff;
      bit_cnt_in = bit_cnt_ff;
      div_in     = div_ff;
      rem_in     = rem_ff;
      acc_in     = acc_ff;
      mem_we     = 1'b0;

      rsp_vld_in    = rsp_vld_ff && !rsp_bus.ready;
      rsp_status_in = rsp_status_ff;
      rsp_key_in    = rsp_key_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_total_in  = rsp_total_ff;

      if (issue) begin
         idx_in = idx_ff + CNT_W'(1);
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               status_in = wrts_pkg::STAT_DONE;
               pick_in   = '0;
               state_in  = S_DONE;
               unique case (req_bus.func)
                  wrts_pkg::FUNC_CLEAR: begin
                     count_in = '0;
                     total_in = '0;
                  end
                  wrts_pkg::FUNC_ADD: begin
                     if (add_ok) begin
                        mem_we   = 1'b1;
                        count_in = count_ff + CNT_W'(1);
                        total_in = total_ff + TOTAL_W'(new_weight);
                     end else begin
                        status_in = wrts_pkg::STAT_REJECT;
                     end
                  end
                  default: begin
                     if (count_ff == '0) begin
                        status_in = wrts_pkg::STAT_EMPTY;
                     end else begin
                        rnd_in     = req_bus.random_word;
                        bit_cnt_in = '0;
                        rem_in     = '0;
                        idx_in     = '0;
                        acc_in     = '0;
                        if ((req_bus.func == wrts_pkg::FUNC_PICK_AVOID) && avoid_on) begin
                           state_in = S_SUM;
                        end else begin
                           skip_in  = 1'b0;
                           div_in   = total_ff;
                           state_in = S_DIV;
                        end
                     end
                  end
               endcase
            end
         end

         // Sum of the weights of entries not carrying the avoided key
         S_SUM: begin
            if (rv_ff && !rd_avoided) begin
               acc_in = acc_ff + rd_weight;
            end
            if ((idx_ff == count_ff) && !rv_ff) begin
               if ((acc_ff != '0) && (acc_ff != total_ff)) begin
                  skip_in = 1'b1;
                  div_in  = acc_ff;
               end else begin
                  skip_in = 1'b0;
                  div_in  = total_ff;
               end
               state_in = S_DIV;
            end
         end

         // Random word modulo the selected total
         S_DIV: begin
            rnd_in     = {rnd_ff[RND_W-2:0], 1'b0};
            bit_cnt_in = bit_cnt_ff + 1'b1;
            if (!trial_sub[TOTAL_W]) begin
               rem_in = trial_sub[TOTAL_W-1:0];
            end else begin
               rem_in = trial[TOTAL_W-1:0];
            end
            if (bit_cnt_ff == wrts_pkg::RND_CNT_W'(RND_W - 1)) begin
               idx_in   = '0;
               found_in = 1'b0;
               state_in = S_WALK;
            end
         end

         // Walk of the cumulative weights, first entry 0 as fallback
         S_WALK: begin
            if (rv_ff && !found_ff) begin
               if (rd_idx_ff == '0) begin
                  pick_in = rdata_ff.key;
               end
               if (!(skip_ff && rd_avoided)) begin
                  if (rem_ff < rd_weight) begin
                     pick_in  = rdata_ff.key;
                     found_in = 1'b1;
                  end else begin
                     rem_in = rem_ff - rd_weight;
                  end
               end
            end
            if (found_ff || ((idx_ff == count_ff) && !rv_ff)) begin
               state_in = S_DONE;
            end
         end

         S_DONE: begin
            if (out_free) begin
               rsp_vld_in    = 1'b1;
               rsp_status_in = status_ff;
               rsp_key_in    = pick_ff;
               rsp_count_in  = wrts_pkg::COUNT_W'(count_ff);
               rsp_total_in  = total_ff;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         count_ff   <= '0;
         total_ff   <= '0;
         rv_ff      <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         total_ff   <= total_in;
         rv_ff      <= rv_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   // Datapath and response payload
   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      rd_idx_ff     <= rd_idx_in;
      skip_ff       <= skip_in;
      found_ff      <= found_in;
      pick_ff       <= pick_in;
      status_ff     <= status_in;
      rnd_ff        <= rnd_in;
      bit_cnt_ff    <= bit_cnt_in;
      div_ff        <= div_in;
      rem_ff        <= rem_in;
      acc_ff        <= acc_in;
      rsp_status_ff <= rsp_status_in;
      rsp_key_ff    <= rsp_key_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_total_ff  <= rsp_total_in;
   end

   // Table memory: write on add, registered read otherwise
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_ff[count_ff[ADDR_W-1:0]] <= wr_entry;
      end else begin
         rdata_ff <= mem_ff[idx_ff[ADDR_W-1:0]];
      end
   end

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff  <= '1;
         limit_ff <= wrts_pkg::LIMIT_RESET;
         avoid_ff <= wrts_pkg::AVOID_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            wrts_pkg::CSR_VALID_MASK:  mask_ff  <= csr_wdata[wrts_pkg::MASK_W-1:0];
            wrts_pkg::CSR_INDEX_LIMIT: limit_ff <= csr_wdata[wrts_pkg::LIMIT_W-1:0];
            wrts_pkg::CSR_AVOID_INDEX: avoid_ff <= csr_wdata[wrts_pkg::AVOID_W-1:0];
            default: ;
         endcase
      end
   end

   assign rsp_bus.valid      = rsp_vld_ff;
   assign rsp_bus.status     = rsp_status_ff;
   assign rsp_bus.picked_key = rsp_key_ff;
   assign rsp_bus.count_out  = rsp_count_ff;
   assign rsp_bus.total_out  = rsp_total_ff;

endmodule

// ===== hdl/wrts_checker.sv =====
// Port-level assertions for the weighted random table selector, with bind.
module wrts_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [wrts_pkg::STAT_W-1:0]       rsp_status,
   input logic [wrts_pkg::KEY_W-1:0]        rsp_picked_key,
   input logic [wrts_pkg::COUNT_W-1:0]      rsp_count_out,
   input logic [wrts_pkg::TOTAL_W-1:0]      rsp_total_out
);

   // A stalled response holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_status)
         && $stable(rsp_picked_key) && $stable(rsp_count_out) && $stable(rsp_total_out)))
      else $error("response changed while stalled");

   // An empty table has no weight, and a table with entries has some
   a_count_total: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_count_out == '0) == (rsp_total_out == '0)))
      else $error("entry count and weight total disagree");

   // An empty pick reports an empty table
   a_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == wrts_pkg::STAT_EMPTY))
         |-> ((rsp_count_out == '0) && (rsp_picked_key == '0)))
      else $error("empty status with a non-empty table");

   // Rejected adds never carry a picked key
   a_reject_key: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == wrts_pkg::STAT_REJECT)) |-> (rsp_picked_key == '0))
      else $error("rejected add with a picked key");

   // Entry count never exceeds the table depth
   a_count_max: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (int'(rsp_count_out) <= wrts_pkg::TABLE_DEPTH))
      else $error("entry count beyond table depth");

endmodule

bind weighted_random_table_selector wrts_checker u_wrts_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_bus.valid),
   .rsp_ready      (rsp_bus.ready),
   .rsp_status     (rsp_bus.status),
   .rsp_picked_key (rsp_bus.picked_key),
   .rsp_count_out  (rsp_bus.count_out),
   .rsp_total_out  (rsp_bus.total_out)
);
